/* rtl/pvs_pkg.sv */
// Shared types and constants for the pose-to-velocity servo.
// Holds the datapath command codes, the control/status structs and the arctangent table.
// No dependencies.
package pvs_pkg;

    // Configuration port geometry
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STANDOFF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_DB    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_DB      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGULAR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd7;

    // Pi in Q16.16 radians, the ceiling of the rotation angle
    localparam logic [17:0] PI_Q16 = 18'd205887;

    // Datapath operations
    typedef logic [4:0] t_op;
    localparam t_op OP_NONE      = 5'd0;
    localparam t_op OP_LOAD      = 5'd1;
    localparam t_op OP_TICK_OUT  = 5'd2;
    localparam t_op OP_ACC_CLR   = 5'd3;
    localparam t_op OP_MUL_SQ_E  = 5'd4;
    localparam t_op OP_ACC_ADD   = 5'd5;
    localparam t_op OP_SQRT_LIN  = 5'd6;
    localparam t_op OP_EN_LOAD   = 5'd7;
    localparam t_op OP_LIN_ZERO  = 5'd8;
    localparam t_op OP_MUL_GN    = 5'd9;
    localparam t_op OP_N_LOAD    = 5'd10;
    localparam t_op OP_MUL_LIN   = 5'd11;
    localparam t_op OP_DIV_LIN   = 5'd12;
    localparam t_op OP_LIN_Q     = 5'd13;
    localparam t_op OP_LIN_SH    = 5'd14;
    localparam t_op OP_MUL_SQ_V  = 5'd15;
    localparam t_op OP_SQRT_ANG  = 5'd16;
    localparam t_op OP_VN_LOAD   = 5'd17;
    localparam t_op OP_CORDIC    = 5'd18;
    localparam t_op OP_ANGLE     = 5'd19;
    localparam t_op OP_ANG_ZERO  = 5'd20;
    localparam t_op OP_MUL_GA    = 5'd21;
    localparam t_op OP_MAG       = 5'd22;
    localparam t_op OP_MUL_ANG   = 5'd23;
    localparam t_op OP_DIV_ANG   = 5'd24;
    localparam t_op OP_ANG_Q     = 5'd25;
    localparam t_op OP_POSE_DONE = 5'd26;

    typedef struct packed {
        t_op        op;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic sqrt_done;
        logic div_done;
        logic lin_db;
        logic clamp;
        logic acc_zero;
        logic cordic_last;
        logic ang_db;
    } t_stat;

    // Arctangent of 2^-i in Q2.30 radians
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* rtl/pvs_sqrt.sv */
// Bit-serial floor square root, one result bit per cycle.
// Depends on nothing but the clock and reset.
module pvs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [59:0] i_radicand,
    output logic        o_done,
    output logic [29:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [59:0] r_rad;
    logic [32:0] r_rem;
    logic [29:0] r_root;
    logic [32:0] rem_sh;
    logic [32:0] trial;

    // Bring down two radicand bits, try the next root bit
    assign rem_sh = {r_rem[30:0], r_rad[59:58]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd29) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[57:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[28:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[28:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

/* rtl/pvs_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but the clock and reset.
module pvs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [52:0] i_num,
    input  logic [29:0] i_den,
    output logic        o_done,
    output logic [52:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [52:0] r_q;
    logic [29:0] r_rem;
    logic [29:0] r_den;
    logic [30:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem, r_q[52]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd52) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift dividend out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[51:0], fits};
            if (fits) begin
                r_rem <= 30'(rem_sh - {1'b0, r_den});
            end else begin
                r_rem <= rem_sh[29:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

/* rtl/pvs_dp.sv */
// Datapath: configuration, working registers, shared multiplier, CORDIC,
// stored commands and the output register. Uses pvs_pkg, pvs_sqrt, pvs_div.
module pvs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pvs_pkg::t_cmd                       i_cmd,
    output pvs_pkg::t_stat                      o_stat,
    input  logic                                i_cfg_we,
    input  logic [pvs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pvs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [23:0]                  i_pos_x,
    input  logic signed [23:0]                  i_pos_y,
    input  logic signed [23:0]                  i_pos_z,
    input  logic signed [15:0]                  i_quat_x,
    input  logic signed [15:0]                  i_quat_y,
    input  logic signed [15:0]                  i_quat_z,
    input  logic signed [15:0]                  i_quat_w,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [20:0]                  o_lin_x,
    output logic signed [20:0]                  o_lin_y,
    output logic signed [20:0]                  o_lin_z,
    output logic signed [23:0]                  o_ang_x,
    output logic signed [23:0]                  o_ang_y,
    output logic signed [23:0]                  o_ang_z,
    output logic                                o_stale
);
    import pvs_pkg::*;

    // Configuration
    logic [19:0] r_standoff;
    logic [23:0] r_trans_gain;
    logic [23:0] r_rot_gain;
    logic [19:0] r_trans_db;
    logic [17:0] r_rot_db;
    logic [19:0] r_max_lin;
    logic [22:0] r_max_ang;
    logic [15:0] r_timeout;

    // Persistent state
    logic signed [20:0] r_lin [3];
    logic signed [23:0] r_ang [3];
    logic               r_seen;
    logic [15:0]        r_ticks;
    logic               r_out_valid;

    // Working registers
    logic signed [24:0] r_e [3];
    logic signed [16:0] r_v [3];
    logic signed [15:0] r_we;
    logic signed [53:0] r_prod;
    logic [59:0]        r_acc;
    logic [25:0]        r_en;
    logic [29:0]        r_vn;
    logic               r_clamp;
    logic               r_neg;
    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [31:0] r_z;
    logic [4:0]         r_ci;
    logic [17:0]        r_angle;
    logic [22:0]        r_mag;

    logic signed [26:0] ma;
    logic signed [26:0] mb;
    logic [53:0]        prod_abs;
    logic [53:0]        rnd16;
    logic [37:0]        hi16;
    logic [20:0]        lin_q;
    logic [23:0]        ang_q;
    logic               sqrt_start;
    logic [59:0]        radicand;
    logic               sqrt_done;
    logic [29:0]        root;
    logic               div_start;
    logic [52:0]        div_num;
    logic [29:0]        div_den;
    logic               div_done;
    logic [52:0]        quot;
    logic [16:0]        av0, av1, av2;
    logic [1:0]         big;
    logic               flip;
    logic [16:0]        we_abs;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [30:0]        z_pos;
    logic [32:0]        ang_sum;
    logic [18:0]        ang_full;
    logic [15:0]        ticks_nx;
    logic               stale_nx;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_standoff   <= 20'd32768;
            r_trans_gain <= 24'd52429;
            r_rot_gain   <= 24'd32768;
            r_trans_db   <= 20'd655;
            r_rot_db     <= 18'd1311;
            r_max_lin    <= 20'd6554;
            r_max_ang    <= 23'd32768;
            r_timeout    <= 16'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STANDOFF:    r_standoff   <= i_cfg_data[19:0];
                CFG_TRANS_GAIN:  r_trans_gain <= i_cfg_data[23:0];
                CFG_ROT_GAIN:    r_rot_gain   <= i_cfg_data[23:0];
                CFG_TRANS_DB:    r_trans_db   <= i_cfg_data[19:0];
                CFG_ROT_DB:      r_rot_db     <= i_cfg_data[17:0];
                CFG_MAX_LINEAR:  r_max_lin    <= i_cfg_data[19:0];
                CFG_MAX_ANGULAR: r_max_ang    <= i_cfg_data[22:0];
                CFG_TIMEOUT:     r_timeout    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Select multiplier operands
    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.op)
            OP_MUL_SQ_E: begin
                ma = {{2{r_e[i_cmd.k][24]}}, r_e[i_cmd.k]};
                mb = {{2{r_e[i_cmd.k][24]}}, r_e[i_cmd.k]};
            end
            OP_MUL_GN: begin
                ma = {3'b0, r_trans_gain};
                mb = {1'b0, r_en};
            end
            OP_MUL_LIN: begin
                ma = r_clamp ? {7'b0, r_max_lin} : {3'b0, r_trans_gain};
                mb = {{2{r_e[i_cmd.k][24]}}, r_e[i_cmd.k]};
            end
            OP_MUL_SQ_V: begin
                ma = {{10{r_v[i_cmd.k][16]}}, r_v[i_cmd.k]};
                mb = {{10{r_v[i_cmd.k][16]}}, r_v[i_cmd.k]};
            end
            OP_MUL_GA: begin
                ma = {3'b0, r_rot_gain};
                mb = {9'b0, r_angle};
            end
            OP_MUL_ANG: begin
                ma = {4'b0, r_mag};
                mb = {{10{r_v[i_cmd.k][16]}}, r_v[i_cmd.k]};
            end
            default: ;
        endcase
    end

    // Rounding helpers on the registered product, and the signed quotients
    assign prod_abs = r_prod[53] ? 54'(-r_prod) : r_prod;
    assign rnd16    = prod_abs + 54'd32768;
    assign hi16     = rnd16[53:16];
    assign lin_q    = r_neg ? 21'(~quot[20:0] + 21'd1) : quot[20:0];
    assign ang_q    = (r_neg ^ r_we[15]) ? 24'(~quot[23:0] + 24'd1) : quot[23:0];

    // Half-turn: pick the dominant axis, earlier axis wins ties
    assign av0  = r_v[0][16] ? 17'(-r_v[0]) : r_v[0];
    assign av1  = r_v[1][16] ? 17'(-r_v[1]) : r_v[1];
    assign av2  = r_v[2][16] ? 17'(-r_v[2]) : r_v[2];
    assign big  = (av0 < av1) ? ((av1 < av2) ? 2'd2 : 2'd1) : ((av0 < av2) ? 2'd2 : 2'd0);
    assign flip = (r_we == '0) && r_v[big][16];

    assign we_abs = r_we[15] ? 17'(-{r_we[15], r_we}) : {1'b0, r_we};

    // CORDIC step terms
    assign dx = r_y >>> r_ci;
    assign dy = r_x >>> r_ci;

    assign z_pos    = r_z[31] ? '0 : r_z[30:0];
    assign ang_sum  = {1'b0, z_pos, 1'b0} + 33'd8192;
    assign ang_full = ang_sum[32:14];

    // Square root and divider starts
    assign sqrt_start = (i_cmd.op == OP_SQRT_LIN) || (i_cmd.op == OP_SQRT_ANG);
    assign radicand   = (i_cmd.op == OP_SQRT_ANG) ? {r_acc[31:0], 28'b0} : r_acc;
    assign div_start  = (i_cmd.op == OP_DIV_LIN) || (i_cmd.op == OP_DIV_ANG);
    always_comb begin
        if (i_cmd.op == OP_DIV_ANG) begin
            div_num = {prod_abs[38:0], 14'b0} + {24'b0, r_vn[29:1]};
            div_den = r_vn;
        end else begin
            div_num = prod_abs[52:0] + {28'b0, r_en[25:1]};
            div_den = {4'b0, r_en};
        end
    end

    pvs_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    pvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        case (i_cmd.op)
            OP_LOAD: begin
                r_e[0] <= {i_pos_x[23], i_pos_x};
                r_e[1] <= {i_pos_y[23], i_pos_y};
                r_e[2] <= 25'({i_pos_z[23], i_pos_z} - {5'b0, r_standoff});
                r_v[0] <= {i_quat_w[15], i_quat_w};
                r_v[1] <= {i_quat_z[15], i_quat_z};
                r_v[2] <= 17'(-{i_quat_y[15], i_quat_y});
                r_we   <= i_quat_x;
                r_acc  <= '0;
            end
            OP_ACC_CLR: r_acc <= '0;
            OP_ACC_ADD: r_acc <= r_acc + {6'b0, r_prod};
            OP_EN_LOAD: r_en <= root[25:0];
            OP_N_LOAD:  r_clamp <= hi16 > {18'b0, r_max_lin};
            OP_DIV_LIN: r_neg <= r_prod[53];
            OP_DIV_ANG: r_neg <= r_prod[53];
            OP_SQRT_ANG: begin
                if (flip) begin
                    r_v[0] <= 17'(-r_v[0]);
                    r_v[1] <= 17'(-r_v[1]);
                    r_v[2] <= 17'(-r_v[2]);
                end
            end
            OP_VN_LOAD: begin
                r_vn <= root;
                r_x  <= {2'b0, we_abs[16:0], 14'b0};
                r_y  <= {3'b0, root};
                r_z  <= '0;
                r_ci <= '0;
            end
            OP_CORDIC: begin
                r_ci <= r_ci + 5'd1;
                if (!r_y[32] && (r_y != '0)) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + $signed(atan_lut(r_ci));
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - $signed(atan_lut(r_ci));
                end
            end
            OP_ANGLE: r_angle <= (ang_full > {1'b0, PI_Q16}) ? PI_Q16 : ang_full[17:0];
            OP_MAG:   r_mag <= (hi16 > {15'b0, r_max_ang}) ? r_max_ang : hi16[22:0];
            default: ;
        endcase
    end

    // Tick bookkeeping
    assign ticks_nx = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign stale_nx = !r_seen || (ticks_nx > r_timeout);

    // Stored commands, pose bookkeeping and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_lin[k] <= '0;
                r_ang[k] <= '0;
            end
            r_seen      <= 1'b0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LIN_ZERO: begin
                    for (int k = 0; k < 3; k++) r_lin[k] <= '0;
                end
                OP_ANG_ZERO: begin
                    for (int k = 0; k < 3; k++) r_ang[k] <= '0;
                end
                OP_LIN_Q:  r_lin[i_cmd.k] <= lin_q;
                OP_LIN_SH: r_lin[i_cmd.k] <= r_prod[53] ? 21'(~hi16[20:0] + 21'd1)
                                                        : hi16[20:0];
                OP_ANG_Q:  r_ang[i_cmd.k] <= ang_q;
                OP_POSE_DONE: begin
                    r_seen  <= 1'b1;
                    r_ticks <= '0;
                end
                OP_TICK_OUT: r_ticks <= ticks_nx;
                default: ;
            endcase
            if (i_cmd.op == OP_TICK_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_TICK_OUT) begin
            o_lin_x <= stale_nx ? '0 : r_lin[0];
            o_lin_y <= stale_nx ? '0 : r_lin[1];
            o_lin_z <= stale_nx ? '0 : r_lin[2];
            o_ang_x <= stale_nx ? '0 : r_ang[0];
            o_ang_y <= stale_nx ? '0 : r_ang[1];
            o_ang_z <= stale_nx ? '0 : r_ang[2];
            o_stale <= stale_nx;
        end
    end

    assign o_out_valid = r_out_valid;

    // Status to the controller
    always_comb begin
        o_stat.out_free    = !r_out_valid || !i_out_stall;
        o_stat.sqrt_done   = sqrt_done;
        o_stat.div_done    = div_done;
        o_stat.lin_db      = r_en < {6'b0, r_trans_db};
        o_stat.clamp       = r_clamp;
        o_stat.acc_zero    = (r_acc == '0);
        o_stat.cordic_last = (r_ci == 5'd29);
        o_stat.ang_db      = r_angle < r_rot_db;
    end
endmodule

/* rtl/pvs_ctrl.sv */
// Controller: sequences the datapath through one pose or tick transaction.
// Uses pvs_pkg for the command and status structs.
module pvs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rot_en,
    input  logic           i_in_valid,
    input  logic           i_kind,
    input  pvs_pkg::t_stat i_stat,
    output pvs_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);
    import pvs_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_TICK     = 5'd1;
    localparam logic [4:0] S_LSQ_MUL  = 5'd2;
    localparam logic [4:0] S_LSQ_ACC  = 5'd3;
    localparam logic [4:0] S_LSQRT    = 5'd4;
    localparam logic [4:0] S_LSQRT_W  = 5'd5;
    localparam logic [4:0] S_LCHK     = 5'd6;
    localparam logic [4:0] S_LNORM    = 5'd7;
    localparam logic [4:0] S_LK_MUL   = 5'd8;
    localparam logic [4:0] S_LK_NEXT  = 5'd9;
    localparam logic [4:0] S_LK_DIVW  = 5'd10;
    localparam logic [4:0] S_A_START  = 5'd11;
    localparam logic [4:0] S_ASQ_MUL  = 5'd12;
    localparam logic [4:0] S_ASQ_ACC  = 5'd13;
    localparam logic [4:0] S_ACHK     = 5'd14;
    localparam logic [4:0] S_ASQRT_W  = 5'd15;
    localparam logic [4:0] S_CORDIC   = 5'd16;
    localparam logic [4:0] S_ANGLE    = 5'd17;
    localparam logic [4:0] S_ADB      = 5'd18;
    localparam logic [4:0] S_AMAG     = 5'd19;
    localparam logic [4:0] S_AK_MUL   = 5'd20;
    localparam logic [4:0] S_AK_DIV   = 5'd21;
    localparam logic [4:0] S_AK_DIVW  = 5'd22;
    localparam logic [4:0] S_DONE     = 5'd23;

    logic [4:0] r_state, n_state;
    logic [1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // Next state and command
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        o_cmd.op = OP_NONE;
        o_cmd.k  = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_k      = '0;
                    n_state  = i_kind ? S_TICK : S_LSQ_MUL;
                end
            end
            S_TICK: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_TICK_OUT;
                    n_state  = S_IDLE;
                end
            end
            // Linear: sum of squared errors
            S_LSQ_MUL: begin
                o_cmd.op = OP_MUL_SQ_E;
                n_state  = S_LSQ_ACC;
            end
            S_LSQ_ACC: begin
                o_cmd.op = OP_ACC_ADD;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_LSQRT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_LSQ_MUL;
                end
            end
            S_LSQRT: begin
                o_cmd.op = OP_SQRT_LIN;
                n_state  = S_LSQRT_W;
            end
            S_LSQRT_W: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.op = OP_EN_LOAD;
                    n_state  = S_LCHK;
                end
            end
            S_LCHK: begin
                if (i_stat.lin_db) begin
                    o_cmd.op = OP_LIN_ZERO;
                    n_state  = S_A_START;
                end else begin
                    o_cmd.op = OP_MUL_GN;
                    n_state  = S_LNORM;
                end
            end
            S_LNORM: begin
                o_cmd.op = OP_N_LOAD;
                n_state  = S_LK_MUL;
            end
            // Linear: per-axis scale
            S_LK_MUL: begin
                o_cmd.op = OP_MUL_LIN;
                n_state  = S_LK_NEXT;
            end
            S_LK_NEXT: begin
                if (i_stat.clamp) begin
                    o_cmd.op = OP_DIV_LIN;
                    n_state  = S_LK_DIVW;
                end else begin
                    o_cmd.op = OP_LIN_SH;
                    n_k      = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    n_state  = (r_k == 2'd2) ? S_A_START : S_LK_MUL;
                end
            end
            S_LK_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_LIN_Q;
                    n_k      = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    n_state  = (r_k == 2'd2) ? S_A_START : S_LK_MUL;
                end
            end
            // Angular: norm of the error vector
            S_A_START: begin
                n_k = '0;
                if (!i_rot_en) begin
                    o_cmd.op = OP_ANG_ZERO;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_ACC_CLR;
                    n_state  = S_ASQ_MUL;
                end
            end
            S_ASQ_MUL: begin
                o_cmd.op = OP_MUL_SQ_V;
                n_state  = S_ASQ_ACC;
            end
            S_ASQ_ACC: begin
                o_cmd.op = OP_ACC_ADD;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_ACHK;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_ASQ_MUL;
                end
            end
            S_ACHK: begin
                if (i_stat.acc_zero) begin
                    o_cmd.op = OP_ANG_ZERO;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_SQRT_ANG;
                    n_state  = S_ASQRT_W;
                end
            end
            S_ASQRT_W: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.op = OP_VN_LOAD;
                    n_state  = S_CORDIC;
                end
            end
            S_CORDIC: begin
                o_cmd.op = OP_CORDIC;
                if (i_stat.cordic_last) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                o_cmd.op = OP_ANGLE;
                n_state  = S_ADB;
            end
            S_ADB: begin
                if (i_stat.ang_db) begin
                    o_cmd.op = OP_ANG_ZERO;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_MUL_GA;
                    n_state  = S_AMAG;
                end
            end
            S_AMAG: begin
                o_cmd.op = OP_MAG;
                n_state  = S_AK_MUL;
            end
            // Angular: per-axis scale
            S_AK_MUL: begin
                o_cmd.op = OP_MUL_ANG;
                n_state  = S_AK_DIV;
            end
            S_AK_DIV: begin
                o_cmd.op = OP_DIV_ANG;
                n_state  = S_AK_DIVW;
            end
            S_AK_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_ANG_Q;
                    n_k      = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    n_state  = (r_k == 2'd2) ? S_DONE : S_AK_MUL;
                end
            end
            S_DONE: begin
                o_cmd.op = OP_POSE_DONE;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
endmodule

/* rtl/pose_to_velocity_servo_top.sv */
// Top level of the pose-to-velocity servo: controller plus datapath.
// Uses pvs_pkg, pvs_ctrl and pvs_dp.
//
//   port group   dir   handshake                    payload
//   in           in    i_in_valid / o_in_stall      i_kind, i_pos_*, i_quat_*
//   out          out   o_out_valid / i_out_stall    o_lin_*, o_ang_*, o_stale
//   cfg          in    i_cfg_we                     i_cfg_index, i_cfg_data
//
// A tick transaction waits only for the output register to be free.
// A pose transaction holds two square-root waits, a CORDIC run and up to six
// divider waits on one shared divider; deadband and unclamped linear paths
// are shorter.
// Reset is synchronous, active low; stored commands and the tick count clear.
// The input side stalls while a transaction is in work; a stalled output
// holds its result while the next input transaction is taken.
module pose_to_velocity_servo_top #(
    parameter bit ROTATE_EN = 1'b1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic signed [23:0]                  i_pos_x,
    input  logic signed [23:0]                  i_pos_y,
    input  logic signed [23:0]                  i_pos_z,
    input  logic signed [15:0]                  i_quat_x,
    input  logic signed [15:0]                  i_quat_y,
    input  logic signed [15:0]                  i_quat_z,
    input  logic signed [15:0]                  i_quat_w,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [20:0]                  o_lin_x,
    output logic signed [20:0]                  o_lin_y,
    output logic signed [20:0]                  o_lin_z,
    output logic signed [23:0]                  o_ang_x,
    output logic signed [23:0]                  o_ang_y,
    output logic signed [23:0]                  o_ang_z,
    output logic                                o_stale,
    input  logic                                i_cfg_we,
    input  logic [pvs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pvs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pvs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rot_en   (ROTATE_EN),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pvs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_quat_w    (i_quat_w),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_lin_x     (o_lin_x),
        .o_lin_y     (o_lin_y),
        .o_lin_z     (o_lin_z),
        .o_ang_x     (o_ang_x),
        .o_ang_y     (o_ang_y),
        .o_ang_z     (o_ang_z),
        .o_stale     (o_stale)
    );

    // An accepted transaction makes the input side stall in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // A stale result carries zero commands
    a_stale_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stale) |-> (o_lin_x == '0 && o_lin_y == '0 && o_lin_z == '0 &&
                                      o_ang_x == '0 && o_ang_y == '0 && o_ang_z == '0))
        else $error("stale result with nonzero command");

    // Square root and divider never finish together
    a_unit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.sqrt_done |-> !stat.div_done)
        else $error("square root and divider overlap");
endmodule

/* tb/testbench.sv */
// Self-checking testbench for pose_to_velocity_servo_top.
// Depends on pvs_pkg and the servo RTL; holds its own velocity-command predictor.
`timescale 1ns / 100ps

module testbench;
    import pvs_pkg::*;

    typedef struct packed {
        logic               kind;
        logic signed [23:0] px, py, pz;
        logic signed [15:0] qx, qy, qz, qw;
    } t_item;

    typedef struct packed {
        logic signed [20:0] lx, ly, lz;
        logic signed [23:0] ax, ay, az;
        logic               stale;
    } t_result;

    typedef struct packed {
        t_item   item;
        logic    typed;
        t_result want;
    } t_dir_row;

    localparam logic KIND_POSE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    logic clk = 1'b0, rst_n = 1'b0;
    logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
    logic kind = 1'b0;
    logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
    logic signed [20:0] lin_x, lin_y, lin_z;
    logic signed [23:0] ang_x, ang_y, ang_z;
    logic stale;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pose_to_velocity_servo_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_kind(kind),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_quat_x(quat_x), .i_quat_y(quat_y), .i_quat_z(quat_z), .i_quat_w(quat_w),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_lin_x(lin_x), .o_lin_y(lin_y), .o_lin_z(lin_z),
        .o_ang_x(ang_x), .o_ang_y(ang_y), .o_ang_z(ang_z), .o_stale(stale),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Predictor state and register copies
    longint unsigned standoff_q, tgain_q, rgain_q, tdb_q, rdb_q, maxlin_q, maxang_q, tmo_q;
    logic signed [20:0] held_lin [3];
    logic signed [23:0] held_ang [3];
    bit pose_valid;
    longint unsigned tick_age;

    t_result cmd_queue [$];
    int   n_errors = 0;
    bit   out_quiet = 0;
    bit   hold_long = 0;

    const longint arctan_q30 [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Round half away from zero
    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned m, q;
        m = (num < 0) ? longint'(-num) : longint'(num);
        q = (m + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint half_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arctan_q30[i];
            end else begin
                x -= dx; y += dy; z -= arctan_q30[i];
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    task automatic servo_pose(input t_item it);
        longint e [3], a [3], sq [3], w, h, ang, c;
        longint unsigned s, en, n, vn, mag;
        int big;
        // Translation command
        e[0] = longint'(it.px);
        e[1] = longint'(it.py);
        e[2] = longint'(it.pz) - longint'(standoff_q);
        s = 0;
        for (int k = 0; k < 3; k++) begin
            s += longint'(e[k] * e[k]);
            held_lin[k] = '0;
            held_ang[k] = '0;
        end
        en = floor_sqrt(s);
        if (en >= tdb_q) begin
            n = (tgain_q * en + 32768) >> 16;
            for (int k = 0; k < 3; k++)
                held_lin[k] = 21'((n > maxlin_q) ? round_div(longint'(maxlin_q) * e[k], en)
                                                 : round_div(longint'(tgain_q) * e[k], 65536));
        end
        // Rotation command from the error quaternion (w, x, y, z) = (qx, qw, qz, -qy)
        w = longint'(it.qx);
        a[0] = longint'(it.qw) * 16384;
        a[1] = longint'(it.qz) * 16384;
        a[2] = -longint'(it.qy) * 16384;
        for (int k = 0; k < 3; k++) sq[k] = a[k] * a[k];
        s = longint'(sq[0]) + longint'(sq[1]) + longint'(sq[2]);
        if (s != 0) begin
            if (w == 0) begin
                big = (sq[0] < sq[1]) ? ((sq[1] < sq[2]) ? 2 : 1)
                                      : ((sq[0] < sq[2]) ? 2 : 0);
                if (a[big] < 0)
                    for (int k = 0; k < 3; k++) a[k] = -a[k];
            end
            vn = floor_sqrt(s);
            h = half_angle(((w < 0) ? -w : w) * 16384, longint'(vn));
            ang = (h * 2 + 8192) >>> 14;
            if (ang > 205887) ang = 205887;
            if (longint'(ang) >= longint'(rdb_q)) begin
                mag = (rgain_q * longint'(ang) + 32768) >> 16;
                if (mag > maxang_q) mag = maxang_q;
                for (int k = 0; k < 3; k++) begin
                    c = round_div(longint'(mag) * a[k], vn);
                    held_ang[k] = 24'((w < 0) ? -c : c);
                end
            end
        end
        pose_valid = 1'b1;
        tick_age = 0;
    endtask

    function automatic t_result servo_tick();
        t_result r;
        bit old;
        if (tick_age < 65535) tick_age++;
        old = !pose_valid || tick_age > tmo_q;
        r.lx = old ? '0 : held_lin[0];
        r.ly = old ? '0 : held_lin[1];
        r.lz = old ? '0 : held_lin[2];
        r.ax = old ? '0 : held_ang[0];
        r.ay = old ? '0 : held_ang[1];
        r.az = old ? '0 : held_ang[2];
        r.stale = old;
        return r;
    endfunction

    task automatic servo_reset();
        standoff_q = 32768; tgain_q = 52429; rgain_q = 32768; tdb_q = 655;
        rdb_q = 1311; maxlin_q = 6554; maxang_q = 32768; tmo_q = 50;
        for (int k = 0; k < 3; k++) begin
            held_lin[k] = '0;
            held_ang[k] = '0;
        end
        pose_valid = 1'b0;
        tick_age = 0;
    endtask

    // Write one register, update the predictor copy; the caller drops the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_STANDOFF:    standoff_q = val & 64'hFFFFF;
            CFG_TRANS_GAIN:  tgain_q    = val & 64'hFFFFFF;
            CFG_ROT_GAIN:    rgain_q    = val & 64'hFFFFFF;
            CFG_TRANS_DB:    tdb_q      = val & 64'hFFFFF;
            CFG_ROT_DB:      rdb_q      = val & 64'h3FFFF;
            CFG_MAX_LINEAR:  maxlin_q   = val & 64'hFFFFF;
            CFG_MAX_ANGULAR: maxang_q   = val & 64'h7FFFFF;
            default:         tmo_q      = val & 64'hFFFF;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one transaction, hold until taken, then predict
    task automatic send_item(input t_item it, input int gap,
                             input bit typed, input t_result want);
        in_valid <= 1'b1;
        kind     <= it.kind;
        pos_x <= it.px; pos_y <= it.py; pos_z <= it.pz;
        quat_x <= it.qx; quat_y <= it.qy; quat_z <= it.qz; quat_w <= it.qw;
        do @(posedge clk); while (in_stall);
        if (it.kind == KIND_POSE) begin
            servo_pose(it);
        end else begin
            cmd_queue.push_back(typed ? want : servo_tick());
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] rand_q_comp();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int r;
        it.kind = ($urandom_range(0, 9) < 5) ? KIND_TICK : KIND_POSE;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            it.px = 24'($urandom); it.py = 24'($urandom); it.pz = 24'($urandom);
        end else if (r == 1) begin
            it.px = 24'($signed($urandom_range(0, 2000)) - 1000);
            it.py = 24'($signed($urandom_range(0, 2000)) - 1000);
            it.pz = 24'(longint'(standoff_q) + longint'($urandom_range(0, 2000)) - 1000);
        end else begin
            it.px = 24'($signed($urandom_range(0, 13107200)) - 6553600);
            it.py = 24'($signed($urandom_range(0, 13107200)) - 6553600);
            it.pz = 24'($signed($urandom_range(0, 13107200)) - 6553600);
        end
        r = $urandom_range(0, 9);
        it.qx = rand_q_comp(); it.qy = rand_q_comp();
        it.qz = rand_q_comp(); it.qw = rand_q_comp();
        case (r)
            0: begin
                it.qx = 16'($urandom); it.qy = 16'($urandom);
                it.qz = 16'($urandom); it.qw = 16'($urandom);
            end
            1: begin
                it.qx = '0; it.qy = '0; it.qz = '0; it.qw = '0;
            end
            2: begin
                // half turn, often with tied magnitudes
                it.qx = '0;
                if ($urandom_range(0, 1)) begin
                    it.qz = $urandom_range(0, 1) ? it.qw : -it.qw;
                    it.qy = $urandom_range(0, 1) ? it.qw : -it.qw;
                end
            end
            3: begin
                it.qx = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                it.qy = '0; it.qz = '0; it.qw = '0;
            end
            4, 5: begin
                // small rotation around the desired orientation
                it.qx = $urandom_range(0, 1) ? 16'sd16000 : -16'sd16000;
                it.qy = 16'($signed($urandom_range(0, 800)) - 400);
                it.qz = 16'($signed($urandom_range(0, 800)) - 400);
                it.qw = 16'($signed($urandom_range(0, 800)) - 400);
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic void compare(input t_result want, input t_result got);
        if (want !== got) begin
            if (n_errors < 10)
                $display("mismatch at %0t: want lin %0d %0d %0d ang %0d %0d %0d stale %0b,",
                         $time, want.lx, want.ly, want.lz, want.ax, want.ay, want.az,
                         want.stale,
                         " got lin %0d %0d %0d ang %0d %0d %0d stale %0b",
                         got.lx, got.ly, got.lz, got.ax, got.ay, got.az, got.stale);
            n_errors++;
        end
    endfunction

    // Output side: check each transaction, stall at random or for a long hold
    initial begin
        int stall_left;
        t_result got;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                got = '{lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, stale};
                if (cmd_queue.size() == 0) begin
                    if (n_errors < 10) $display("unexpected result at %0t", $time);
                    n_errors++;
                end else begin
                    compare(cmd_queue.pop_front(), got);
                end
            end
            if (hold_long) begin
                hold_long = 0;
                stall_left = 3000;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (out_quiet || $urandom_range(0, 9) < 7) begin
                out_stall <= 1'b0;
            end else begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Wait for all results, then let an in-flight pose finish
    task automatic drain();
        in_valid <= 1'b0;
        while (cmd_queue.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    function automatic t_item mk(logic k, int x, int y, int z,
                                 int a, int b, int c, int d);
        t_item it;
        it = '{k, 24'(x), 24'(y), 24'(z), 16'(a), 16'(b), 16'(c), 16'(d)};
        return it;
    endfunction

    t_dir_row dir_rows [$];
    t_result zero_cmd, stale_cmd;

    initial begin
        t_item tick_it;
        servo_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        zero_cmd  = '0;
        stale_cmd = '0;
        stale_cmd.stale = 1'b1;
        tick_it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0);

        // Directed: reset state, extremes of fields, special cases
        dir_rows.push_back('{tick_it, 1'b1, stale_cmd});
        dir_rows.push_back('{mk(KIND_POSE, 0, 0, 32768, 0, 0, 0, 0), 1'b0, zero_cmd});
        dir_rows.push_back('{tick_it, 1'b1, zero_cmd});
        dir_rows.push_back('{mk(KIND_POSE, 6553600, 6553600, 6553600,
                                16384, 0, 0, 0), 1'b0, zero_cmd});
        dir_rows.push_back('{tick_it, 1'b0, zero_cmd});
        dir_rows.push_back('{mk(KIND_POSE, -6553600, -6553600, -6553600,
                                -16384, 0, 0, 0), 1'b0, zero_cmd});
        dir_rows.push_back('{tick_it, 1'b0, zero_cmd});
        dir_rows.push_back('{mk(KIND_POSE, 8388607, -8388608, 100, 0, 16384, 0, 0),
                             1'b0, zero_cmd});
        dir_rows.push_back('{tick_it, 1'b0, zero_cmd});
        dir_rows.push_back('{mk(KIND_POSE, 1000, 0, 0, 0, 0, -16384, 0), 1'b0, zero_cmd});
        dir_rows.push_back('{tick_it, 1'b0, zero_cmd});
        dir_rows.push_back('{mk(KIND_POSE, 0, 300, 0, 0, -8192, 8192, -8192),
                             1'b0, zero_cmd});
        dir_rows.push_back('{tick_it, 1'b0, zero_cmd});
        dir_rows.push_back('{mk(KIND_POSE, 50, 50, 50, -1, 32767, -32768, 32767),
                             1'b0, zero_cmd});
        dir_rows.push_back('{tick_it, 1'b0, zero_cmd});
        dir_rows.push_back('{mk(KIND_POSE, 20000, -20000, 40000, -32768, 100, 100, 100),
                             1'b0, zero_cmd});
        dir_rows.push_back('{tick_it, 1'b0, zero_cmd});
        dir_rows.push_back('{mk(KIND_POSE, 4000, 0, 0, 11585, 0, 0, -11585),
                             1'b0, zero_cmd});
        dir_rows.push_back('{mk(KIND_TICK, -1, -1, -1, -1, -1, -1, -1), 1'b0, zero_cmd});
        dir_rows.push_back('{tick_it, 1'b0, zero_cmd});

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, pick_gap(), dir_rows[i].typed, dir_rows[i].want);
        drain();

        // Register settings: extremes, zeros, out of range, then random
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 8; r++) begin
                longint unsigned v;
                case (ph)
                    0: v = (r == 0 || r == 3 || r == 5) ? 655360 :
                           (r == 1 || r == 2) ? 16777215 :
                           (r == 4) ? 0 : (r == 6) ? 4194304 : 65535;
                    1: v = 0;
                    2: v = (r == 7) ? 3 : $urandom_range(0, 600000);
                    3: v = $urandom & 24'hFFFFFF;
                    4: v = (r == 4) ? 262143 : (r == 7) ? 0 : $urandom_range(0, 200000);
                    default: v = (r == 7) ? $urandom_range(0, 60)
                                          : $urandom_range(0, 400000);
                endcase
                write_reg(CFG_IDX_W'(r), v);
            end
            cfg_we <= 1'b0;
            out_quiet = (ph == 5);
            if (ph == 2) hold_long = 1;
            for (int n = 0; n < 125; n++)
                send_item(rand_item(), out_quiet ? 0 : pick_gap(), 1'b0, zero_cmd);
            drain();
        end

        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
